FILE: rtl/slbsm_pkg.sv
// ----------------------------------------------------------------------------
// slbsm_pkg
// Shared widths, reset values and address region codes for the serial
// loaded bank switch mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package slbsm_pkg;

  localparam int CFG_DATA_W  = 6;
  localparam int CFG_INDEX_W = 2;

  localparam logic [4:0] CONTROL_RESET  = 5'h0C;
  localparam logic [4:0] PRG_MODE_FORCE = 5'h0C;
  localparam logic [5:0] PRG_OUTER_SIZE = 6'd32;
  localparam logic [4:0] CHR_FULL_SIZE  = 5'd16;
  localparam logic [4:0] CHR_BIT3_SIZE  = 5'd8;
  localparam logic [4:0] CHR_BIT2_SIZE  = 5'd4;
  localparam logic [4:0] CHR_BIT1_SIZE  = 5'd2;
  localparam logic [2:0] RAM_FOUR_WIN   = 3'd4;
  localparam logic [2:0] RAM_TWO_WIN    = 3'd2;
  localparam logic [2:0] SHIFT_LAST     = 3'd4;

  localparam logic [5:0] PRG_BANKS_RESET = 6'd16;
  localparam logic [4:0] CHR_BANKS_RESET = 5'd0;
  localparam logic [2:0] RAM_WIN_RESET   = 3'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PRG_ROM_BANKS   = 2'd0,
    CFG_CHR_ROM_BANKS   = 2'd1,
    CFG_PRG_RAM_WINDOWS = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    REGION_CONTROL = 2'd0,
    REGION_CHR0    = 2'd1,
    REGION_CHR1    = 2'd2,
    REGION_PRG     = 2'd3
  } region_t;

  typedef enum logic [1:0] {
    PRG_MODE_32K_A    = 2'd0,
    PRG_MODE_32K_B    = 2'd1,
    PRG_MODE_FIX_LOW  = 2'd2,
    PRG_MODE_FIX_HIGH = 2'd3
  } prg_mode_t;

endpackage

`default_nettype wire

FILE: rtl/serial_loaded_bank_switch_mapper.sv
// ----------------------------------------------------------------------------
// serial_loaded_bank_switch_mapper
// Five-bit serial register loader with control, CHR, PRG and PRG-RAM bank
// registers; each write produces the resulting bank mapping.
// ----------------------------------------------------------------------------
// An accepted write updates bank and output registers together. Throughput:
// one write per cycle unless an unread output holds in_ready low; the state
// update and mapping logic settle between the bank and output registers.
// Reset: synchronous, clears the loader and bank registers, sets control to
// 0x0C and the size registers to 16 PRG banks, no CHR banks, one RAM window.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_loaded_bank_switch_mapper
  import slbsm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             write_data,
  input  wire logic [15:0]            write_addr,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  mirror_mode,
  output logic [4:0]                  prg_slot0_bank,
  output logic [4:0]                  prg_slot1_bank,
  output logic [4:0]                  chr_slot0_bank,
  output logic [4:0]                  chr_slot1_bank,
  output logic [1:0]                  prg_ram_bank
);

  logic [5:0] prg_rom_banks;
  logic [4:0] chr_rom_banks;
  logic [2:0] prg_ram_windows;

  logic [4:0] shift_value, shift_value_next;
  logic [2:0] shift_count, shift_count_next;
  logic [4:0] control_reg, control_reg_next;
  logic [4:0] chr_bank0, chr_bank0_next;
  logic [4:0] chr_bank1, chr_bank1_next;
  logic [4:0] prg_bank_reg, prg_bank_reg_next;
  logic [1:0] ram_bank_reg, ram_bank_reg_next;

  logic       accept;
  logic [4:0] loaded;
  logic [4:0] kept;
  logic       outer_en;
  logic [4:0] outer;
  logic [4:0] bank;
  logic [4:0] last;
  logic [4:0] p0, p1, c0, c1;
  region_t    region;
  prg_mode_t  mode;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign region   = region_t'(write_addr[14:13]);
  assign outer_en = (prg_rom_banks == PRG_OUTER_SIZE) && (chr_rom_banks != CHR_FULL_SIZE);
  assign loaded   = shift_value | (5'({4'b0, write_data[0]} << shift_count));

  always_comb begin
    kept    = {4'b0, loaded[0]};
    kept[1] = (chr_rom_banks >= CHR_BIT1_SIZE) && loaded[1];
    kept[2] = (chr_rom_banks >= CHR_BIT2_SIZE) && loaded[2];
    kept[3] = (chr_rom_banks >= CHR_BIT3_SIZE) && loaded[3];
    kept[4] = (chr_rom_banks == CHR_FULL_SIZE) && loaded[4];
  end

  always_comb begin
    shift_value_next  = shift_value;
    shift_count_next  = shift_count;
    control_reg_next  = control_reg;
    chr_bank0_next    = chr_bank0;
    chr_bank1_next    = chr_bank1;
    prg_bank_reg_next = prg_bank_reg;
    ram_bank_reg_next = ram_bank_reg;
    if (write_data[7]) begin
      shift_value_next = '0;
      shift_count_next = '0;
      control_reg_next = control_reg | PRG_MODE_FORCE;
    end else if (shift_count < SHIFT_LAST) begin
      shift_value_next = loaded;
      shift_count_next = shift_count + 3'd1;
    end else begin
      shift_value_next = '0;
      shift_count_next = '0;
      unique case (region)
        REGION_CONTROL: control_reg_next = loaded;
        REGION_CHR0, REGION_CHR1: begin
          if (region == REGION_CHR0) begin
            chr_bank0_next = kept;
          end else begin
            chr_bank1_next = kept;
          end
          if (chr_rom_banks < CHR_BIT3_SIZE) begin
            if (prg_ram_windows == RAM_FOUR_WIN) begin
              ram_bank_reg_next = loaded[3:2];
            end else if (prg_ram_windows == RAM_TWO_WIN) begin
              ram_bank_reg_next = {1'b0, loaded[3]};
            end
          end
          if (chr_rom_banks != CHR_FULL_SIZE && prg_rom_banks == PRG_OUTER_SIZE) begin
            prg_bank_reg_next = {loaded[4], prg_bank_reg[3:0]};
          end
        end
        REGION_PRG: prg_bank_reg_next = {prg_bank_reg[4], loaded[3:0]};
        default: control_reg_next = control_reg;
      endcase
    end
  end

  always_comb begin
    outer = outer_en ? {prg_bank_reg_next[4], 4'b0} : 5'b0;
    bank  = {outer[4], prg_bank_reg_next[3:0]};
    last  = outer_en ? {outer[4], 4'hF} : 5'(prg_rom_banks - 6'd1);
    mode  = prg_mode_t'(control_reg_next[3:2]);
    unique case (mode)
      PRG_MODE_FIX_HIGH: begin
        p0 = bank;
        p1 = last;
      end
      PRG_MODE_FIX_LOW: begin
        p0 = outer;
        p1 = bank;
      end
      default: begin
        p0 = {bank[4:1], 1'b0};
        p1 = {bank[4:1], 1'b1};
      end
    endcase
    if (control_reg_next[4]) begin
      c0 = chr_bank0_next;
      c1 = chr_bank1_next;
    end else begin
      c0 = {chr_bank0_next[4:1], 1'b0};
      c1 = {chr_bank0_next[4:1], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_rom_banks   <= PRG_BANKS_RESET;
      chr_rom_banks   <= CHR_BANKS_RESET;
      prg_ram_windows <= RAM_WIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PRG_ROM_BANKS:   prg_rom_banks   <= cfg_data;
        CFG_CHR_ROM_BANKS:   chr_rom_banks   <= cfg_data[4:0];
        CFG_PRG_RAM_WINDOWS: prg_ram_windows <= cfg_data[2:0];
        default:             prg_rom_banks   <= prg_rom_banks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_value  <= '0;
      shift_count  <= '0;
      control_reg  <= CONTROL_RESET;
      chr_bank0    <= '0;
      chr_bank1    <= '0;
      prg_bank_reg <= '0;
      ram_bank_reg <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        shift_value  <= shift_value_next;
        shift_count  <= shift_count_next;
        control_reg  <= control_reg_next;
        chr_bank0    <= chr_bank0_next;
        chr_bank1    <= chr_bank1_next;
        prg_bank_reg <= prg_bank_reg_next;
        ram_bank_reg <= ram_bank_reg_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mirror_mode    <= control_reg_next[1:0];
      prg_slot0_bank <= p0;
      prg_slot1_bank <= p1;
      chr_slot0_bank <= c0;
      chr_slot1_bank <= c1;
      prg_ram_bank   <= ram_bank_reg_next;
    end
  end

endmodule

`default_nettype wire

FILE: test/bank_map_checker.sv
// ----------------------------------------------------------------------------
// bank_map_checker
// Watches the configuration port and both item channels of the serial loaded
// bank switch mapper, tracks the mapper state for every accepted write and
// compares each returned mapping, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module bank_map_checker
  import slbsm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             write_data,
  input  logic [15:0]            write_addr,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             mirror_mode,
  input  logic [4:0]             prg_slot0_bank,
  input  logic [4:0]             prg_slot1_bank,
  input  logic [4:0]             chr_slot0_bank,
  input  logic [4:0]             chr_slot1_bank,
  input  logic [1:0]             prg_ram_bank,
  output int                     mismatch_count,
  output int                     maps_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] mirror;
    logic [4:0] prg0;
    logic [4:0] prg1;
    logic [4:0] chr0;
    logic [4:0] chr1;
    logic [1:0] ram;
  } bank_map_t;

  bank_map_t  expected_maps[$];

  logic [5:0] size_prg;
  logic [4:0] size_chr;
  logic [2:0] size_ram;

  logic [4:0] loader_bits;
  logic [2:0] loader_count;
  logic [4:0] control_q;
  logic [4:0] chr_q[2];
  logic [4:0] prg_q;
  logic [1:0] ram_q;

  task automatic report(input string what, input int got, input int want);
    $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic store_chr_bank(input int which, input logic [4:0] v);
    logic [4:0] kept;
    kept = {4'b0000, v[0]};
    if (size_chr >= CHR_BIT1_SIZE) kept[1] = v[1];
    if (size_chr >= CHR_BIT2_SIZE) kept[2] = v[2];
    if (size_chr >= CHR_BIT3_SIZE) begin
      kept[3] = v[3];
    end else if (size_ram == RAM_FOUR_WIN) begin
      ram_q = v[3:2];
    end else if (size_ram == RAM_TWO_WIN) begin
      ram_q = {1'b0, v[3]};
    end
    if (size_chr == CHR_FULL_SIZE) begin
      kept[4] = v[4];
    end else if (size_prg == PRG_OUTER_SIZE) begin
      prg_q[4] = v[4];
    end
    chr_q[which] = kept;
  endtask

  task automatic apply_cpu_write(input logic [7:0] data, input logic [15:0] addr,
                                 output bank_map_t m);
    logic [4:0] v;
    logic [4:0] outer;
    logic [4:0] bank;
    logic [4:0] last;
    logic       outer_on;
    if (data[7]) begin
      loader_bits  = '0;
      loader_count = '0;
      control_q    = control_q | PRG_MODE_FORCE;
    end else begin
      loader_bits = loader_bits | (5'(data[0]) << loader_count);
      if (loader_count < SHIFT_LAST) begin
        loader_count = loader_count + 3'd1;
      end else begin
        v            = loader_bits;
        loader_bits  = '0;
        loader_count = '0;
        case (region_t'(addr[14:13]))
          REGION_CONTROL: control_q = v;
          REGION_CHR0:    store_chr_bank(0, v);
          REGION_CHR1:    store_chr_bank(1, v);
          default:        prg_q = {prg_q[4], v[3:0]};
        endcase
      end
    end

    outer_on = (size_prg == PRG_OUTER_SIZE) && (size_chr != CHR_FULL_SIZE);
    outer    = outer_on ? {prg_q[4], 4'b0000} : 5'd0;
    bank     = {outer[4], prg_q[3:0]};
    last     = outer_on ? (outer | 5'h0F) : 5'(size_prg - 6'd1);

    m.mirror = control_q[1:0];
    case (prg_mode_t'(control_q[3:2]))
      PRG_MODE_FIX_HIGH: begin
        m.prg0 = bank;
        m.prg1 = last;
      end
      PRG_MODE_FIX_LOW: begin
        m.prg0 = outer;
        m.prg1 = bank;
      end
      default: begin
        m.prg0 = {bank[4:1], 1'b0};
        m.prg1 = {bank[4:1], 1'b1};
      end
    endcase
    if (control_q[4]) begin
      m.chr0 = chr_q[0];
      m.chr1 = chr_q[1];
    end else begin
      m.chr0 = {chr_q[0][4:1], 1'b0};
      m.chr1 = {chr_q[0][4:1], 1'b1};
    end
    m.ram = ram_q;
  endtask

  always @(posedge clk) begin : track
    bank_map_t want;
    bank_map_t pred;
    if (rst) begin
      size_prg       = PRG_BANKS_RESET;
      size_chr       = CHR_BANKS_RESET;
      size_ram       = RAM_WIN_RESET;
      loader_bits    = '0;
      loader_count   = '0;
      control_q      = CONTROL_RESET;
      chr_q[0]       = '0;
      chr_q[1]       = '0;
      prg_q          = '0;
      ram_q          = '0;
      mismatch_count = 0;
      expected_maps.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_PRG_ROM_BANKS:   size_prg = cfg_data;
          CFG_CHR_ROM_BANKS:   size_chr = cfg_data[4:0];
          CFG_PRG_RAM_WINDOWS: size_ram = cfg_data[2:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_maps.size() == 0) begin
          report("result with no write pending, slot0 PRG bank", prg_slot0_bank, -1);
        end else begin
          want = expected_maps.pop_front();
          if (mirror_mode !== want.mirror) report("mirror mode", mirror_mode, want.mirror);
          if (prg_slot0_bank !== want.prg0) report("PRG slot0 bank", prg_slot0_bank, want.prg0);
          if (prg_slot1_bank !== want.prg1) report("PRG slot1 bank", prg_slot1_bank, want.prg1);
          if (chr_slot0_bank !== want.chr0) report("CHR slot0 bank", chr_slot0_bank, want.chr0);
          if (chr_slot1_bank !== want.chr1) report("CHR slot1 bank", chr_slot1_bank, want.chr1);
          if (prg_ram_bank !== want.ram) report("PRG RAM bank", prg_ram_bank, want.ram);
        end
      end
      if (in_valid && in_ready) begin
        apply_cpu_write(write_data, write_addr, pred);
        expected_maps.push_back(pred);
      end
    end
    maps_outstanding <= expected_maps.size();
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives CPU writes into the serial loaded bank switch mapper under a series
// of cartridge size settings, with random gaps on both channels and one long
// output stall, and gives the verdict from the mapping checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import slbsm_pkg::*;

  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 103;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_LIMIT  = 2000;

  logic                   clk;
  logic                   rst        = 1'b1;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [7:0]             write_data = '0;
  logic [15:0]            write_addr = 16'h8000;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic [1:0]             mirror_mode;
  logic [4:0]             prg_slot0_bank;
  logic [4:0]             prg_slot1_bank;
  logic [4:0]             chr_slot0_bank;
  logic [4:0]             chr_slot1_bank;
  logic [1:0]             prg_ram_bank;
  int                     mismatch_count;
  int                     maps_outstanding;

  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;
  bit hold_request = 1'b0;
  int writes_sent  = 0;

  int prg_sizes[PHASES] = '{32, 16, 1, 32, 32, 8, 63, 0, 32, 16};
  int chr_sizes[PHASES] = '{4, 0, 0, 16, 2, 8, 31, 1, 0, 16};
  int ram_sizes[PHASES] = '{4, 1, 0, 4, 2, 4, 7, 2, 2, 0};

  serial_loaded_bank_switch_mapper i_dut (.*);

  bank_map_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL serial_loaded_bank_switch_mapper");
    $finish;
  end

  initial begin : receiver
    int r;
    int len;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        len = HOLD_CYCLES;
      end else if (rx_steady || r < 60) begin
        out_ready <= 1'b1;
        len = $urandom_range(1, 8);
      end else if (r < 92) begin
        out_ready <= 1'b0;
        len = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        len = $urandom_range(8, 30);
      end
      repeat (len) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_cart_sizes(input int prg, input int chr, input int ram);
    cfg_write(CFG_PRG_ROM_BANKS, CFG_DATA_W'(prg));
    cfg_write(CFG_CHR_ROM_BANKS, CFG_DATA_W'(chr));
    cfg_write(CFG_PRG_RAM_WINDOWS, CFG_DATA_W'(ram));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cpu_write(input logic [7:0] data, input logic [15:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    write_data <= data;
    write_addr <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    writes_sent++;
  endtask

  task automatic serial_load(input region_t region, input logic [4:0] value,
                             input logic [15:0] base);
    logic [15:0] addr;
    addr = base;
    addr[14:13] = region;
    for (int i = 0; i < 5; i++) begin
      cpu_write({1'b0, 6'($urandom), value[i]}, addr);
    end
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (maps_outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic random_writes(input int count);
    int target;
    int kind;
    int n;
    target = writes_sent + count;
    while (writes_sent < target) begin
      if ($urandom_range(0, 30) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 30) == 0) rx_steady = !rx_steady;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        serial_load(region_t'($urandom_range(0, 3)), 5'($urandom),
                    {($urandom_range(0, 7) != 0), 15'($urandom)});
      end else if (kind < 83) begin
        cpu_write(8'h80 | 8'($urandom), 16'($urandom));
      end else if (kind < 93) begin
        n = $urandom_range(1, 4);
        repeat (n) cpu_write({1'b0, 7'($urandom)}, 16'($urandom));
        cpu_write(8'h80 | 8'($urandom), 16'($urandom));
      end else begin
        cpu_write(8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Writes to the unused index must leave the sizes alone.
    cfg_write(CFG_UNUSED, '1);
    set_cart_sizes(prg_sizes[0], chr_sizes[0], ram_sizes[0]);

    cpu_write(8'h80, 16'hFFFF);
    cpu_write(8'hFF, 16'h8000);
    serial_load(REGION_CONTROL, 5'h13, 16'h0000);
    serial_load(REGION_CHR0, 5'h1F, 16'hA000);
    serial_load(REGION_CHR1, 5'h0A, 16'h4000);
    serial_load(REGION_PRG, 5'h1F, 16'hE000);
    cpu_write(8'h01, 16'h8000);
    cpu_write(8'h7F, 16'hBFFF);
    cpu_write(8'h80, 16'h8000);
    serial_load(REGION_CONTROL, 5'h08, 16'h9FFF);
    random_writes(PHASE_ITEMS - 25);
    wait_idle();

    for (int p = 1; p < PHASES; p++) begin
      if (p >= 8) begin
        set_cart_sizes($urandom_range(1, 32), $urandom_range(0, 16), $urandom_range(0, 4));
      end else begin
        set_cart_sizes(prg_sizes[p], chr_sizes[p], ram_sizes[p]);
      end
      if (p == 3) begin
        tx_steady    = 1'b1;
        hold_request = 1'b1;
      end
      random_writes(PHASE_ITEMS);
      wait_idle();
    end

    if (mismatch_count == 0 && maps_outstanding == 0) begin
      $display("PASS serial_loaded_bank_switch_mapper");
    end else begin
      $display("FAIL serial_loaded_bank_switch_mapper");
    end
    $finish;
  end

endmodule
